FILE: design/ecgbr_pkg.sv
// Shared types for the ECG baseline removal filter.
// No dependencies; imported by the top level and the sample ring.
package ecgbr_pkg;

    // Per-transfer command to the sample ring
    typedef struct packed {
        logic push;   // store a sample, fetch the one leaving the window
        logic clear;  // empty the window, rewind the pointer
    } ecgbr_ring_ctrl_t;

endpackage

FILE: design/ecg_baseline_removal_filter.sv
// ECG baseline removal filter: moving-average DC blocker, top level.
// Depends on ecgbr_pkg and ecgbr_ring.
//
// Usage:
//   Input channel s_valid/s_ready carries one signed sample (s_sample) and a
//   clear flag (s_clear). Output channel m_valid/m_ready carries one result,
//   m_filtered, per input transfer, in order.
//   The result is x(n) minus the mean of the last WINDOW samples, computed
//   exactly on WINDOW*y and rounded half away from zero, saturated to
//   SAMPLE_BITS+1 bits. A clear transfer empties the window and returns 0.
// Timing:
//   Six register stages: input/ring read, accumulator, magnitude, reciprocal
//   partial products, quotient estimate, output. Throughput is 1 sample per
//   cycle while the receiver keeps m_ready high; the accumulator update is
//   the only loop and it closes through acc_reg alone.
// Reset:
//   aresetn low empties the pipeline and the window and zeroes the
//   accumulator; s_ready is high the cycle after reset.
// Stall:
//   When the receiver holds m_ready low, the output holds and each stage
//   keeps filling while the one after it can take its sample; once all six
//   stages hold a sample, s_ready drops.
module ecg_baseline_removal_filter import ecgbr_pkg::*; #(
    parameter int WINDOW      = 250,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_clear,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS:0]   m_filtered
);

    localparam int SB    = SAMPLE_BITS;
    localparam int OUT_W = SB + 1;
    localparam int ACC_W = SB + $clog2(WINDOW) + 2;
    localparam int N_W   = ACC_W + 1;               // 2*|acc| + WINDOW
    localparam int DIV   = 2 * WINDOW;
    localparam int SHIFT = N_W;
    localparam int M_W   = SHIFT - $clog2(DIV) + 1;
    localparam int H     = (N_W + 1) / 2;
    localparam int P_W   = N_W + M_W;
    localparam int Q_W   = SB + 2;
    localparam int R_W   = N_W + 1;

    localparam logic [63:0]      RECIP_FULL = (64'd1 << SHIFT) / DIV;
    localparam logic [M_W-1:0]   RECIP      = RECIP_FULL[M_W-1:0];
    localparam logic signed [ACC_W-1:0] K_NEW = ACC_W'(WINDOW - 1);
    localparam logic signed [ACC_W-1:0] K_WIN = ACC_W'(WINDOW);
    localparam logic [Q_W-1:0]   MAX_MAG  = Q_W'((64'd1 << SB) - 64'd1);
    localparam logic [Q_W-1:0]   MIN_MAG  = Q_W'(64'd1 << SB);
    localparam logic [OUT_W-1:0] OUT_MAX  = {1'b0, {SB{1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN  = {1'b1, {SB{1'b0}}};

    // ---------------- pipeline flow control ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, m_valid_reg;
    logic free_out, free5, free4, free3, free2, free1;
    logic s_accept;

    assign free_out = !m_valid_reg || m_ready;
    assign free5    = !v5_reg || free_out;
    assign free4    = !v4_reg || free5;
    assign free3    = !v3_reg || free4;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;
    assign s_ready  = free1;
    assign s_accept = s_valid && free1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (free1)    v1_reg      <= s_valid;
            if (free2)    v2_reg      <= v1_reg;
            if (free3)    v3_reg      <= v2_reg;
            if (free4)    v4_reg      <= v3_reg;
            if (free5)    v5_reg      <= v4_reg;
            if (free_out) m_valid_reg <= v5_reg;
        end
    end

    // ---------------- stage 1: input register and ring read ----------------
    ecgbr_ring_ctrl_t     ring_ctrl;
    logic signed [SB-1:0] old_sample;
    logic signed [SB-1:0] x1_reg;
    logic                 clr1_reg;

    assign ring_ctrl.push  = s_accept && !s_clear;
    assign ring_ctrl.clear = s_accept && s_clear;

    ecgbr_ring #(
        .DEPTH  (WINDOW + 1),
        .DATA_W (SB)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ring_ctrl),
        .wr_data (s_sample),
        .rd_data (old_sample)
    );

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x1_reg   <= s_sample;
            clr1_reg <= s_clear;
        end
    end

    // ---------------- stage 2: scaled accumulator ----------------
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [SB-1:0]    prev_reg, prev_next;
    logic signed [ACC_W-1:0] x_ext, prev_ext, old_ext, delta;
    logic                    adv2;

    assign adv2     = v1_reg && free2;
    assign x_ext    = ACC_W'(x1_reg);
    assign prev_ext = ACC_W'(prev_reg);
    assign old_ext  = ACC_W'(old_sample);
    assign delta    = (x_ext * K_NEW) - (prev_ext * K_WIN) + old_ext;

    always_comb begin
        acc_next  = acc_reg;
        prev_next = prev_reg;
        if (adv2) begin
            if (clr1_reg) begin
                acc_next  = '0;
                prev_next = '0;
            end else begin
                acc_next  = acc_reg + delta;
                prev_next = x1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            prev_reg <= '0;
        end else begin
            acc_reg  <= acc_next;
            prev_reg <= prev_next;
        end
    end

    // ---------------- stage 3: sign and rounding numerator ----------------
    logic [ACC_W-1:0] mag;
    logic [N_W-1:0]   n3_reg;
    logic             neg3_reg;

    assign mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    always_ff @(posedge aclk) begin
        if (v2_reg && free3) begin
            neg3_reg <= acc_reg[ACC_W-1];
            n3_reg   <= {mag, 1'b0} + N_W'(WINDOW);
        end
    end

    // ---------------- stage 4: reciprocal partial products ----------------
    logic [N_W-H+M_W-1:0] pp_hi_reg;
    logic [H+M_W-1:0]     pp_lo_reg;
    logic [N_W-1:0]       n4_reg;
    logic                 neg4_reg;

    always_ff @(posedge aclk) begin
        if (v3_reg && free4) begin
            pp_hi_reg <= (N_W-H+M_W)'(n3_reg[N_W-1:H]) * (N_W-H+M_W)'(RECIP);
            pp_lo_reg <= (H+M_W)'(n3_reg[H-1:0]) * (H+M_W)'(RECIP);
            n4_reg    <= n3_reg;
            neg4_reg  <= neg3_reg;
        end
    end

    // ---------------- stage 5: quotient estimate ----------------
    logic [P_W-1:0] prod;
    logic [Q_W-1:0] q5_reg;
    logic [N_W-1:0] n5_reg;
    logic           neg5_reg;

    assign prod = (P_W'(pp_hi_reg) << H) + P_W'(pp_lo_reg);

    always_ff @(posedge aclk) begin
        if (v4_reg && free5) begin
            q5_reg   <= prod[SHIFT +: Q_W];
            n5_reg   <= n4_reg;
            neg5_reg <= neg4_reg;
        end
    end

    // ---------------- stage 6: correction, saturation, output ----------------
    // estimate is the true quotient or one below it
    logic [R_W-1:0]   rem;
    logic [Q_W-1:0]   q_fix;
    logic [OUT_W-1:0] result;

    assign rem   = R_W'(n5_reg) - (R_W'(q5_reg) * R_W'(DIV));
    assign q_fix = q5_reg + Q_W'(rem >= R_W'(DIV));

    always_comb begin
        if (neg5_reg) begin
            result = (q_fix > MIN_MAG) ? OUT_MIN : OUT_W'(-q_fix);
        end else begin
            result = (q_fix > MAX_MAG) ? OUT_MAX : OUT_W'(q_fix);
        end
    end

    logic signed [OUT_W-1:0] filtered_reg;

    always_ff @(posedge aclk) begin
        if (v5_reg && free_out) begin
            filtered_reg <= result;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_filtered = filtered_reg;

endmodule

FILE: design/ecgbr_ring.sv
// Sample ring for the ECG baseline removal filter: sample memory, per-entry
// valid bits and write pointer. Depends on ecgbr_pkg.
module ecgbr_ring import ecgbr_pkg::*; #(
    parameter int DEPTH  = 251,
    parameter int DATA_W = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ecgbr_ring_ctrl_t         ctrl,
    input  logic signed [DATA_W-1:0] wr_data,
    output logic signed [DATA_W-1:0] rd_data
);

    localparam int PTR_W = $clog2(DEPTH);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic        [DEPTH-1:0]  valid_reg;
    logic        [PTR_W-1:0]  ptr_reg;
    logic        [PTR_W-1:0]  old_addr;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     rd_valid_reg;

    // slot after the write slot holds the sample leaving the window
    assign old_addr = (ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : ptr_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[ptr_reg] <= wr_data;
            rd_data_reg  <= mem[old_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            ptr_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end else if (ctrl.clear) begin
            valid_reg    <= '0;
            ptr_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end else if (ctrl.push) begin
            valid_reg[ptr_reg] <= 1'b1;
            ptr_reg            <= old_addr;
            rd_valid_reg       <= valid_reg[old_addr];
        end
    end

    // never-written entries read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: design/ecgbr_checker.sv
// Port-level checks for the ECG baseline removal filter, bound to the top.
// Depends on ecg_baseline_removal_filter (bind target) only.
module ecgbr_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic signed [SAMPLE_BITS-1:0] s_sample,
    input logic                          s_clear,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS:0]   m_filtered
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_filtered))
        else $error("result changed or dropped while stalled");

    // with the receiver ready every stage can move, so the input is never blocked
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input blocked while receiver is ready");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

    // m_valid stays known (never X or Z) after a non-clear input transfer
    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_clear |=> ##4 !$isunknown(m_valid))
        else $error("output handshake unknown after transfer");

endmodule

bind ecg_baseline_removal_filter ecgbr_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_ecgbr_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_sample   (s_sample),
    .s_clear    (s_clear),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_filtered (m_filtered)
);

FILE: tb/sv/ecg_baseline_removal_filter_chk.sv
// Checker for the ECG baseline removal filter: watches both channels, predicts
// each filtered sample from its own copy of the window and accumulator, and compares.
// Standalone; no package or RTL dependencies.
module ecg_baseline_removal_filter_chk (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic signed [23:0]   s_sample,
    input  logic                 s_clear,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic signed [24:0]   m_filtered,
    output int                   fail_count,
    output int                   awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW     = 250;
    localparam int RING_DEPTH = WINDOW + 1;
    localparam longint OUT_MAX = (longint'(1) << 24) - 1;
    localparam longint OUT_MIN = -(longint'(1) << 24);

    logic signed [23:0] window_ring [RING_DEPTH];
    logic [7:0]         head;
    longint             scaled_acc;
    logic signed [24:0] filtered_q [$];

    function automatic void clear_window();
        for (int i = 0; i < RING_DEPTH; i++) begin
            window_ring[i] = '0;
        end
        head       = '0;
        scaled_acc = 0;
    endfunction

    // Advances the window by one transfer and returns the baseline-removed sample.
    function automatic logic signed [24:0] remove_baseline(logic signed [23:0] x,
                                                          logic clr);
        int     p;
        int     prev;
        int     oldest;
        longint mag;
        longint q;
        longint r;
        if (clr) begin
            clear_window();
            return '0;
        end
        p      = head;
        prev   = (p == 0) ? RING_DEPTH - 1 : p - 1;
        oldest = (p + 1 == RING_DEPTH) ? 0 : p + 1;
        window_ring[p] = x;
        scaled_acc += longint'(WINDOW - 1) * longint'(x)
                    - longint'(WINDOW) * longint'(window_ring[prev])
                    + longint'(window_ring[oldest]);
        head = (p + 1 == RING_DEPTH) ? 8'd0 : 8'(p + 1);
        // round half away from zero on the magnitude, then saturate
        mag = (scaled_acc < 0) ? -scaled_acc : scaled_acc;
        q   = (2 * mag + WINDOW) / (2 * WINDOW);
        if (scaled_acc < 0) begin
            r = (-q < OUT_MIN) ? OUT_MIN : -q;
        end else begin
            r = (q > OUT_MAX) ? OUT_MAX : q;
        end
        return 25'(r);
    endfunction

    initial begin
        fail_count = 0;
        awaiting   = 0;
        clear_window();
    end

    always @(posedge aclk) begin
        logic signed [24:0] want;
        if (!aresetn) begin
            filtered_q.delete();
            clear_window();
            awaiting = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (filtered_q.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none got %0d",
                             $time, m_filtered);
                    fail_count++;
                end else begin
                    want = filtered_q.pop_front();
                    if (m_filtered !== want) begin
                        $display("%0t: filtered expected %0d got %0d",
                                 $time, want, m_filtered);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                filtered_q.push_back(remove_baseline(s_sample, s_clear));
            end
            awaiting = filtered_q.size();
        end
    end

endmodule

FILE: tb/sv/ecg_baseline_removal_filter_tb.sv
// Top of the ECG baseline removal filter testbench: clock, reset, sample stimulus
// with random idling on both channels, and the verdict.
// Depends on ecg_baseline_removal_filter and ecg_baseline_removal_filter_chk.
module ecg_baseline_removal_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 630;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_valid  = 1'b0;
    logic               s_ready;
    logic signed [23:0] s_sample = '0;
    logic               s_clear  = 1'b0;
    logic               m_valid;
    logic               m_ready  = 1'b0;
    logic signed [24:0] m_filtered;

    int fail_count;
    int awaiting;
    int send_idle_pct = 20;
    int recv_idle_pct = 69;

    ecg_baseline_removal_filter dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .s_clear    (s_clear),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered)
    );

    ecg_baseline_removal_filter_chk chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .s_clear    (s_clear),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered),
        .fail_count (fail_count),
        .awaiting   (awaiting)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(2_000_000);
        $display("ecg_baseline_removal_filter: mismatch");
        $finish;
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_sample(input logic [23:0] smp, input logic clr);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        s_clear  <= clr;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Hold the input idle until every predicted sample has come out.
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (awaiting != 0);
    endtask

    initial begin
        int          sent;
        int          seg_len;
        int          mode;
        int          baseline;
        int          noise;
        logic [23:0] smp;
        logic        clr;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: clears, extremes, rounding ties both signs
        send_sample(24'h000000, 1'b1);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h000000, 1'b0);
        send_sample(24'd125, 1'b0);
        send_sample(24'(-125), 1'b0);
        send_sample(24'd1, 1'b0);
        send_sample(24'hFFFFFF, 1'b0);
        send_sample(24'h7FFFFF, 1'b1);
        repeat (4) send_sample(24'h800000, 1'b0);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h555555, 1'b0);
        send_sample(24'hAAAAAA, 1'b0);
        send_sample(24'hFFFFFF, 1'b1);
        send_sample(24'd125, 1'b0);
        send_sample(24'h123456, 1'b1);
        send_sample(24'(-125), 1'b0);
        send_sample(24'(-375), 1'b0);
        drain();

        sent     = 0;
        baseline = 0;
        while (sent < RANDOM_ITEMS) begin
            seg_len = $urandom_range(80, 5);
            mode    = $urandom_range(4, 0);
            for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
                if (sent == RANDOM_ITEMS / 3) begin
                    drain();
                    send_idle_pct = 69;
                    recv_idle_pct = 20;
                end else if (sent == 2 * RANDOM_ITEMS / 3) begin
                    drain();
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                case (mode)
                    0: smp = 24'($urandom);
                    1: smp = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
                    2: begin
                        // slow wander plus small noise, like a drifting electrode
                        baseline += $urandom_range(4000) - 2000;
                        if (baseline > 8_000_000 || baseline < -8_000_000) baseline = 0;
                        noise = $urandom_range(600) - 300;
                        smp = 24'(baseline + noise);
                    end
                    3: smp = (seg_len[0]) ? 24'h7FFFFF : 24'h800000;
                    default: smp = 24'(250 * ($urandom_range(200) - 100) + 125);
                endcase
                clr = ($urandom_range(149) == 0);
                if (clr) smp = 24'($urandom);
                send_sample(smp, clr);
                sent++;
            end
        end

        s_valid <= 1'b0;
        for (int n = 0; n < 50_000 && awaiting != 0; n++) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (fail_count == 0 && awaiting == 0) begin
            $display("ecg_baseline_removal_filter: match");
        end else begin
            $display("ecg_baseline_removal_filter: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/ecgbr_pkg.sv
design/ecgbr_ring.sv
design/ecg_baseline_removal_filter.sv
design/ecgbr_checker.sv
tb/sv/ecg_baseline_removal_filter_chk.sv
tb/sv/ecg_baseline_removal_filter_tb.sv
